// ===== hdl/arpc_pkg.sv =====
// Shared types, codes and constants for the ARP cache responder.
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  localparam logic [15:0] MIN_ARP_LEN    = 16'd28;
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [15:0] OPER_REQUEST   = 16'h0001;

  // Configuration port: 64-bit data, registers at 8-byte spacing.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic {
    REG_OWN_MAC = 1'b0,
    REG_OWN_IP  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_BCAST = 2'd2,
    ACT_HIT   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic        hit;
    logic        free;
    logic [47:0] mac;
  } tok_t;

  // Write command broadcast to all cells; index travels beside it.
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } wr_t;

endpackage

// ===== hdl/arp_cache_responder_unit.sv =====
// Top level: ARP cache and responder built as a chain of entry cells.
// The search token walks the cell chain one entry per cycle; at scan end
//   the cache is written back and the result registered, then moved to the
//   output register. A new item is accepted only once that move is done.
// Reset (synchronous, rst_n low): cache empty, own_mac/own_ip zero, no item
//   in flight, output empty.
module arp_cache_responder_unit #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [15:0]                     in_packet_length,
  input  logic [15:0]                     in_hw_type,
  input  logic [15:0]                     in_proto_type,
  input  logic [15:0]                     in_operation,
  input  logic [47:0]                     in_sender_mac,
  input  logic [31:0]                     in_ip_address,
  input  logic [31:0]                     in_target_ip,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_action,
  output logic [47:0]                     out_mac,
  output logic [31:0]                     out_ip,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [arpc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import arpc_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  // ---------------------------------------------------------------
  // Configuration registers. Register index is the 8-byte slot bit.
  // ---------------------------------------------------------------
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OWN_MAC: own_mac_r <= cfg_pwdata[47:0];
        REG_OWN_IP:  own_ip_r  <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OWN_MAC: cfg_prdata = {16'd0, own_mac_r};
      REG_OWN_IP:  cfg_prdata = {32'd0, own_ip_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer: IDLE takes an item, SCAN waits for the token to leave
  // the last cell, FINISH hands the result to the output register.
  // ---------------------------------------------------------------
  state_t state_r, state_nxt;
  logic   accept;
  logic   scan_done;
  logic   out_load;

  tok_t             tok      [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] hit_idx  [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] free_idx [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] tok_vld_vec;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept)    state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_load)  state_nxt = ST_IDLE;
      default:                  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    scan_done = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall  = 1'b0;
      ST_SCAN:   scan_done = tok[CACHE_ENTRIES].vld;
      // output register may be refilled in the cycle it is taken
      ST_FINISH: out_load  = !out_valid || !out_stall;
      default:   in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Item capture. Validity of a packet is decided at accept.
  // ---------------------------------------------------------------
  logic        mode_r;
  logic        learn_ok_r;
  logic        is_req_r;
  logic [47:0] smac_r;
  logic [31:0] ip_r;
  logic [31:0] tip_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      learn_ok_r <= !in_mode && (in_packet_length >= MIN_ARP_LEN) &&
                    (in_hw_type == HTYPE_ETHERNET) && (in_proto_type == PTYPE_IPV4);
      is_req_r   <= (in_operation == OPER_REQUEST);
      smac_r     <= in_sender_mac;
      ip_r       <= in_ip_address;
      tip_r      <= in_target_ip;
    end
  end

  // ---------------------------------------------------------------
  // Cell chain. The token enters cell 0 at accept, carrying the key.
  // ---------------------------------------------------------------
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    tok[0].vld  = accept;
    tok[0].key  = in_ip_address;
    tok[0].hit  = 1'b0;
    tok[0].free = 1'b0;
    tok[0].mac  = '0;
  end
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .CELL_IDX      (g),
      .IDX_W         (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .tok_in       (tok[g]),
      .hit_idx_in   (hit_idx[g]),
      .free_idx_in  (free_idx[g]),
      .tok_out      (tok[g+1]),
      .hit_idx_out  (hit_idx[g+1]),
      .free_idx_out (free_idx[g+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
    assign tok_vld_vec[g] = tok[g+1].vld;
  end

  // ---------------------------------------------------------------
  // Scan end: learn write-back (match, else first free, else entry 0)
  // and result selection.
  // ---------------------------------------------------------------
  tok_t             tok_end;
  logic [1:0]       fin_action_r, fin_action_nxt;
  logic [47:0]      fin_mac_r, fin_mac_nxt;
  logic [31:0]      fin_ip_r, fin_ip_nxt;

  assign tok_end = tok[CACHE_ENTRIES];

  always_comb begin
    wr.en  = scan_done && learn_ok_r;
    wr.ip  = ip_r;
    wr.mac = smac_r;
    if (tok_end.hit) begin
      wr_idx = hit_idx[CACHE_ENTRIES];
    end else if (tok_end.free) begin
      wr_idx = free_idx[CACHE_ENTRIES];
    end else begin
      wr_idx = '0;
    end
  end

  always_comb begin
    fin_action_nxt = ACT_NONE;
    fin_mac_nxt    = '0;
    fin_ip_nxt     = '0;
    if (mode_r) begin
      if (tok_end.hit) begin
        fin_action_nxt = ACT_HIT;
        fin_mac_nxt    = tok_end.mac;
      end else begin
        fin_action_nxt = ACT_BCAST;
        fin_ip_nxt     = ip_r;
      end
    end else if (learn_ok_r && is_req_r && (tip_r == own_ip_r)) begin
      fin_action_nxt = ACT_REPLY;
      fin_mac_nxt    = smac_r;
      fin_ip_nxt     = ip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      fin_action_r <= fin_action_nxt;
      fin_mac_r    <= fin_mac_nxt;
      fin_ip_r     <= fin_ip_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic        out_valid_r;
  logic [1:0]  out_action_r;
  logic [47:0] out_mac_r;
  logic [31:0] out_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_action_r <= fin_action_r;
      out_mac_r    <= fin_mac_r;
      out_ip_r     <= fin_ip_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_mac    = out_mac_r;
  assign out_ip     = out_ip_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // one search token in the chain at most
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_vec))
    else $error("more than one search token in the cell chain");

  // the token only leaves the chain while the sequencer waits for it
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> (state_r == ST_SCAN))
    else $error("search token left the chain outside the scan");

  // an accepted item blocks the input until its result is handed on
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accept");

  // cache writes only happen at scan end for a valid packet
  a_wr_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (scan_done && !mode_r))
    else $error("cache write outside scan end of a packet");

endmodule

// ===== hdl/arpc_cell.sv =====
// One cache entry plus one stage of the search token chain.
module arpc_cell #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int CELL_IDX      = 0,
  parameter int IDX_W         = $clog2(CACHE_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arpc_pkg::tok_t       tok_in,
  input  logic [IDX_W-1:0]     hit_idx_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  output arpc_pkg::tok_t       tok_out,
  output logic [IDX_W-1:0]     hit_idx_out,
  output logic [IDX_W-1:0]     free_idx_out,
  input  arpc_pkg::wr_t        wr,
  input  logic [IDX_W-1:0]     wr_idx
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        ent_vld_r;
  logic [31:0] ent_ip_r;
  logic [47:0] ent_mac_r;

  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             match;

  assign match = ent_vld_r && (ent_ip_r == tok_in.key);

  // Earlier cells win: only take over hit/free when nothing upstream claimed it.
  always_comb begin
    tok_nxt      = tok_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (!tok_in.hit && match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.mac = ent_mac_r;
      hit_idx_nxt = MY_IDX;
    end
    if (!tok_in.free && !ent_vld_r) begin
      tok_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      ent_vld_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.en && (wr_idx == MY_IDX)) begin
        ent_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (wr.en && (wr_idx == MY_IDX)) begin
      ent_ip_r  <= wr.ip;
      ent_mac_r <= wr.mac;
    end
  end

  assign tok_out      = tok_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

endmodule
